>>> hw/rtl/ppu_pkg.sv
// types, constants and helpers shared by the perspective projection unit
package ppu_pkg;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_X_SCALE  = 2'd0,
      CSR_Y_SCALE  = 2'd1,
      CSR_Z_SCALE  = 2'd2,
      CSR_Z_OFFSET = 2'd3
   } csr_reg_type;

   localparam logic [31:0] X_SCALE_RESET  = 32'h0001_0000;
   localparam logic [31:0] Y_SCALE_RESET  = 32'h0001_0000;
   localparam logic [31:0] Z_SCALE_RESET  = 32'h0001_0000;
   localparam logic [31:0] Z_OFFSET_RESET = 32'h0000_0000;

   // quotient bits produced by the divider, one per stage
   localparam int DIV_STEPS  = 33;
   // divider stages: setup stage, one stage per quotient bit, output stage
   localparam int DIV_LAT    = DIV_STEPS + 2;
   // input, product and sum stages ahead of the divider
   localparam int PIPE_DEPTH = 3 + DIV_LAT;

   // one divided and clamped lane
   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } div_res_type;

   // clamp a sign and magnitude to signed 32 bits
   function automatic div_res_type clamp32(input logic neg, input logic [47:0] mag);
      div_res_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > 48'h0000_8000_0000) begin
            r.value = 32'h8000_0000;
            r.sat   = 1'b1;
         end else begin
            r.value = 32'(48'd0 - mag);
         end
      end else begin
         if (mag > 48'h0000_7FFF_FFFF) begin
            r.value = 32'h7FFF_FFFF;
            r.sat   = 1'b1;
         end else begin
            r.value = mag[31:0];
         end
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ppu_req_if.sv
// input channel: one homogeneous point per beat
interface ppu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_x;
   logic [31:0] in_y;
   logic [31:0] in_z;
   logic [31:0] in_w;

   modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                   input ready);
   modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
                 output ready);
endinterface

>>> hw/rtl/ppu_rsp_if.sv
// result channel: one projected point per beat
interface ppu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_depth;
   logic [31:0] out_w;
   logic        not_divided;
   logic        saturated;

   modport source (output valid, output out_x, output out_y, output out_depth,
                   output out_w, output not_divided, output saturated, input ready);
   modport sink (input valid, input out_x, input out_y, input out_depth,
                 input out_w, input not_divided, input saturated, output ready);
endinterface

>>> hw/rtl/ppu_div.sv
// pipelined restoring divider lane: (num * 65536) / den, truncated, clamped to 32 bits
module ppu_div
   import ppu_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [48:0] num,
   input  logic signed [31:0] den,
   output div_res_type        res
);

   // per-stage state, index 0 is the setup stage
   logic [63:0]          rem_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff  [0:DIV_STEPS];
   logic [31:0]          dmag_ff [0:DIV_STEPS];
   logic [47:0]          nmag_ff [0:DIV_STEPS];
   logic                 neg_ff  [0:DIV_STEPS];
   logic                 nneg_ff [0:DIV_STEPS];
   logic                 zero_ff [0:DIV_STEPS];
   logic                 ovf_ff  [0:DIV_STEPS];
   div_res_type          res_ff;

   logic [48:0] nmag_wide;
   logic [47:0] nmag_in;
   logic [31:0] dmag_in;
   logic [63:0] rem_in;
   logic        ovf_in;

   // setup: magnitudes, shifted numerator and overflow precheck
   always_comb begin
      nmag_wide = num[48] ? 49'(-num) : num;
      nmag_in   = nmag_wide[47:0];
      dmag_in   = den[31] ? 32'(-den) : den;
      rem_in    = {nmag_in, 16'd0};
      ovf_in    = ({1'b0, rem_in[63:33]} >= dmag_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in;
         quo_ff[0]  <= '0;
         dmag_ff[0] <= dmag_in;
         nmag_ff[0] <= nmag_in;
         neg_ff[0]  <= num[48] ^ den[31];
         nneg_ff[0] <= num[48];
         zero_ff[0] <= (den == 32'sd0);
         ovf_ff[0]  <= ovf_in;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [63:0] sub;
      logic        take;
      assign sub  = {32'd0, dmag_ff[k]} << (DIV_STEPS - 1 - k);
      assign take = (rem_ff[k] >= sub);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? rem_ff[k] - sub : rem_ff[k];
            quo_ff[k+1]  <= quo_ff[k] | (DIV_STEPS'(take) << (DIV_STEPS - 1 - k));
            dmag_ff[k+1] <= dmag_ff[k];
            nmag_ff[k+1] <= nmag_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            nneg_ff[k+1] <= nneg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   // select undivided value, overflow saturation or quotient, then clamp
   div_res_type res_in;
   always_comb begin
      if (zero_ff[DIV_STEPS]) begin
         res_in = clamp32(nneg_ff[DIV_STEPS], nmag_ff[DIV_STEPS]);
      end else if (ovf_ff[DIV_STEPS]) begin
         res_in.value = neg_ff[DIV_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         res_in.sat   = 1'b1;
      end else begin
         res_in = clamp32(neg_ff[DIV_STEPS], 48'(quo_ff[DIV_STEPS]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

>>> hw/rtl/perspective_point_projection_unit.sv
// perspective projection of Q16.16 points with pipelined perspective divide
// Takes one point (x, y, z, w) per beat and gives one projected point per beat, at a
// sustained rate of one point per clock while results are taken. The stages are an
// input register, a multiply stage, a floor and depth-sum stage, then a divider of 35
// stages (setup, one quotient bit per stage for 33 bits, and a clamp stage) in each
// of three lanes. The whole pipeline advances whenever the output stage is empty or
// being taken, so a stalled result holds every stage in place. Configuration writes
// are taken at any time but must only be made while no point is in flight.
module perspective_point_projection_unit
   import ppu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ppu_req_if.sink     req_chan,
   ppu_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   logic [31:0] x_scale_ff, y_scale_ff, z_scale_ff, z_offset_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff  <= X_SCALE_RESET;
         y_scale_ff  <= Y_SCALE_RESET;
         z_scale_ff  <= Z_SCALE_RESET;
         z_offset_ff <= Z_OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_X_SCALE:  x_scale_ff  <= csr_wr_data;
            CSR_Y_SCALE:  y_scale_ff  <= csr_wr_data;
            CSR_Z_SCALE:  z_scale_ff  <= csr_wr_data;
            CSR_Z_OFFSET: z_offset_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic                  en;

   assign en             = !vld_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign vld_in         = {vld_ff[PIPE_DEPTH-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // clip w delay line, tap 0 is the input register
   logic [31:0] z_ff [0:PIPE_DEPTH-1];
   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0] <= req_chan.in_z;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            z_ff[i] <= z_ff[i-1];
         end
      end
   end

   // input register
   logic signed [31:0] x_ff, y_ff, w_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_chan.in_x;
         y_ff <= req_chan.in_y;
         w_ff <= req_chan.in_w;
      end
   end

   // products, exact Q32.32
   logic signed [63:0] px_ff, py_ff, pz_ff, pw_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= 64'($signed(x_scale_ff)) * 64'(x_ff);
         py_ff <= 64'($signed(y_scale_ff)) * 64'(y_ff);
         pz_ff <= 64'($signed(z_scale_ff)) * 64'($signed(z_ff[0]));
         pw_ff <= 64'($signed(z_offset_ff)) * 64'(w_ff);
      end
   end

   // floor to Q16.16 and depth sum at full width
   logic signed [48:0] nx_ff, ny_ff, nz_ff;
   logic signed [47:0] fx, fy, fz, fw;
   always_comb begin
      fx = px_ff[63:16];
      fy = py_ff[63:16];
      fz = pz_ff[63:16];
      fw = pw_ff[63:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= 49'(fx);
         ny_ff <= 49'(fy);
         nz_ff <= 49'(fz) + 49'(fw);
      end
   end

   // divider lanes
   div_res_type res_x, res_y, res_z;

   ppu_div u_div_x (.clock(clock), .en(en), .num(nx_ff), .den($signed(z_ff[2])),
                    .res(res_x));
   ppu_div u_div_y (.clock(clock), .en(en), .num(ny_ff), .den($signed(z_ff[2])),
                    .res(res_y));
   ppu_div u_div_z (.clock(clock), .en(en), .num(nz_ff), .den($signed(z_ff[2])),
                    .res(res_z));

   // result beat
   assign rsp_chan.valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_chan.out_x       = res_x.value;
   assign rsp_chan.out_y       = res_y.value;
   assign rsp_chan.out_depth   = res_z.value;
   assign rsp_chan.out_w       = z_ff[PIPE_DEPTH-1];
   assign rsp_chan.not_divided = (z_ff[PIPE_DEPTH-1] == 32'd0);
   assign rsp_chan.saturated   = res_x.sat | res_y.sat | res_z.sat;

endmodule

>>> test/perspective_point_projection_unit_tb.sv
// testbench for the perspective projection unit: directed table, random points, predictor check
module perspective_point_projection_unit_tb
   import ppu_pkg::*;
;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] w;
   } point_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] depth;
      logic [31:0] w;
      logic        not_divided;
      logic        saturated;
   } projected_type;

   typedef struct packed {
      logic          typed;
      point_type     pt;
      projected_type res;
   } directed_row_type;

   localparam int NUM_DIRECTED    = 16;
   localparam int NUM_PHASES      = 8;
   localparam int POINTS_PER_PHASE = 236;
   localparam int MAX_REPORTS     = 10;

   // directed points under the reset coefficients; typed rows carry their result
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{1'b1, {32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000},
              {32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0}},
      '{1'b1, {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
              {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}},
      '{1'b1, {32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0005_0000},
              {32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0}},
      '{1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000},
              {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_0001, 1'b0, 1'b1}},
      '{1'b0, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, '0},
      '{1'b0, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, '0},
      '{1'b0, {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000}, '0},
      '{1'b0, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF}, '0},
      '{1'b0, {32'hFFFF_0000, 32'h0000_8000, 32'hFFFE_0000, 32'h0001_0000}, '0},
      '{1'b0, {32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001}, '0},
      '{1'b0, {32'h1234_5678, 32'h9ABC_DEF0, 32'h0001_0000, 32'hFFFF_0000}, '0},
      '{1'b0, {32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF}, '0},
      '{1'b0, {32'h0000_0003, 32'hFFFF_FFFD, 32'h0007_0000, 32'h0000_0000}, '0},
      '{1'b0, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000}, '0},
      '{1'b0, {32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, '0},
      '{1'b0, {32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_0002, 32'h0001_0001}, '0}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wr_data;

   ppu_req_if req_bus ();
   ppu_rsp_if rsp_bus ();

   // coefficients as the block holds them
   logic [31:0]   coeff [4];
   projected_type pending_points [$];
   int            idle_pct;
   int            stall_pct;
   int            mismatches;

   perspective_point_projection_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

   // divide one lane by clip w, then clamp to 32 bits
   function automatic logic [31:0] divide_lane(input longint num, input longint den,
                                               inout logic sat);
      logic       neg;
      bit [63:0]  mag;
      bit [63:0]  dmag;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      neg = (num < 0);
      if (den != 0) begin
         dmag = (den < 0) ? 64'(-den) : 64'(den);
         neg  = (num < 0) != (den < 0);
         mag  = (mag << 16) / dmag;
         if (mag == 0) neg = 1'b0;
      end
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   // perspective matrix with floored products, then the divide by clip w
   function automatic projected_type project_point(input point_type p);
      projected_type r;
      longint        px;
      longint        py;
      longint        pz;
      longint        cw;
      logic          sat;
      sat = 1'b0;
      cw  = longint'($signed(p.z));
      px  = (longint'($signed(coeff[CSR_X_SCALE])) * longint'($signed(p.x))) >>> 16;
      py  = (longint'($signed(coeff[CSR_Y_SCALE])) * longint'($signed(p.y))) >>> 16;
      pz  = ((longint'($signed(coeff[CSR_Z_SCALE])) * cw) >>> 16)
          + ((longint'($signed(coeff[CSR_Z_OFFSET])) * longint'($signed(p.w))) >>> 16);
      r.x           = divide_lane(px, cw, sat);
      r.y           = divide_lane(py, cw, sat);
      r.depth       = divide_lane(pz, cw, sat);
      r.w           = p.z;
      r.not_divided = (cw == 0);
      r.saturated   = sat;
      return r;
   endfunction

   // half full-range words, the rest small values, extremes and zero
   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         5, 6, 7: return 32'($urandom_range(32'h7FFFF) - 32'h40000);
         8: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0001;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         9: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // send one point and queue its expected result on the accepting beat
   task automatic send_point(input point_type p, input logic typed,
                             input projected_type res);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_x  <= p.x;
      req_bus.in_y  <= p.y;
      req_bus.in_z  <= p.z;
      req_bus.in_w  <= p.w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_points.push_back(typed ? res : project_point(p));
   endtask

   // hold the sender until the pipeline is empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic write_coeffs(input logic [31:0] vals [4]);
      csr_reg_type idx;
      idx = idx.first();
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx;
         csr_wr_data <= vals[i];
         @(posedge clock);
         coeff[i] = vals[i];
         idx = idx.next();
      end
      csr_wr_en <= 1'b0;
   endtask

   // result receiver with random stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // compare each result beat with the oldest expected point
   always @(posedge clock) begin
      projected_type got;
      projected_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_depth, rsp_bus.out_w,
                rsp_bus.not_divided, rsp_bus.saturated};
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: %h", got);
         end else begin
            want = pending_points.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch x %h/%h y %h/%h depth %h/%h w %h/%h nd %b/%b sat %b/%b",
                           want.x, got.x, want.y, got.y, want.depth, got.depth,
                           want.w, got.w, want.not_divided, got.not_divided,
                           want.saturated, got.saturated);
            end
         end
      end
   end

   initial begin
      logic [31:0] vals [4];
      point_type   p;
      int          guard;
      mismatches    = 0;
      idle_pct      = 0;
      stall_pct     = 0;
      coeff[CSR_X_SCALE]  = X_SCALE_RESET;
      coeff[CSR_Y_SCALE]  = Y_SCALE_RESET;
      coeff[CSR_Z_SCALE]  = Z_SCALE_RESET;
      coeff[CSR_Z_OFFSET] = Z_OFFSET_RESET;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_X_SCALE;
      csr_wr_data   <= '0;
      req_bus.valid <= 1'b0;
      req_bus.in_x  <= '0;
      req_bus.in_y  <= '0;
      req_bus.in_z  <= '0;
      req_bus.in_w  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset coefficients
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_point(DIRECTED[i].pt, DIRECTED[i].typed, DIRECTED[i].res);

      // random phases, each with its own coefficients and idling mix
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         case (ph)
            0: vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            1: vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            2: vals = '{32'h0001_3333, 32'h0001_BB67, 32'h0001_0A3D, 32'hFFFF_E000};
            3: vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
            default: begin
               foreach (vals[k]) vals[k] = random_word();
            end
         endcase
         write_coeffs(vals);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            p = {random_word(), random_word(), random_word(), random_word()};
            send_point(p, 1'b0, '0);
         end
      end

      // wait out the pipeline
      req_bus.valid <= 1'b0;
      guard = 0;
      while (pending_points.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatches == 0 && pending_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_req_if.sv
hw/rtl/ppu_rsp_if.sv
hw/rtl/ppu_div.sv
hw/rtl/perspective_point_projection_unit.sv
test/perspective_point_projection_unit_tb.sv
